@@ rtl/tss_pkg.sv @@
// ----------------------------------------------------------------------------
// tss_pkg
// shared widths, action and match codes, and the command format that
// travels from the front end to the execution engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tss_pkg;

  localparam int TIME_W        = 63;
  localparam int PRICE_W       = 32;
  localparam int INDEX_W       = 10;
  localparam int COUNT_W       = 11;
  localparam int DEPTH_DEFAULT = 1024;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_CLEAR  = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;
  localparam logic [1:0] ACT_READ   = 2'd3;

  localparam logic [1:0] MODE_EXACT = 2'd0;
  localparam logic [1:0] MODE_NEXT  = 2'd1;
  localparam logic [1:0] MODE_PREV  = 2'd2;

  typedef struct packed {
    logic [1:0]                op;
    logic                      mode_ok;
    logic [1:0]                mode;
    logic [TIME_W-1:0]         tval;
    logic signed [PRICE_W-1:0] price;
    logic [INDEX_W-1:0]        ridx;
  } cmd_t;

endpackage

@@ rtl/tss_front.sv @@
// ----------------------------------------------------------------------------
// tss_front
// input stage: takes a transfer, classifies it into a command and hands it
// to the command queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tss_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         action,
  input  logic [tss_pkg::TIME_W-1:0]         entry_time,
  input  logic signed [tss_pkg::PRICE_W-1:0] entry_price,
  input  logic [tss_pkg::TIME_W-1:0]         query_time,
  input  logic [1:0]                         match_mode,
  input  logic [tss_pkg::INDEX_W-1:0]        read_index,
  output logic                               cmd_valid,
  output tss_pkg::cmd_t                      cmd,
  input  logic                               queue_full
);

  logic hold_valid;
  logic accept;

  assign in_stall  = hold_valid && queue_full;
  assign accept    = in_valid && !in_stall;
  assign cmd_valid = hold_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (hold_valid && !queue_full) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.op      <= action;
      cmd.mode    <= match_mode;
      cmd.mode_ok <= match_mode inside {tss_pkg::MODE_EXACT, tss_pkg::MODE_NEXT,
                                        tss_pkg::MODE_PREV};
      cmd.tval    <= (action == tss_pkg::ACT_ADD) ? entry_time : query_time;
      cmd.price   <= entry_price;
      cmd.ridx    <= read_index;
    end
  end

endmodule

@@ rtl/tss_queue.sv @@
// ----------------------------------------------------------------------------
// tss_queue
// short command queue between the front end and the execution engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tss_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  input  tss_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output tss_pkg::cmd_t head
);

  tss_pkg::cmd_t                 slots [tss_pkg::QUEUE_DEPTH];
  logic [tss_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [tss_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [tss_pkg::QUEUE_AW:0]    fill;
  logic                          push;

  assign full      = (fill == (tss_pkg::QUEUE_AW + 1)'(tss_pkg::QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign push      = push_valid && !full;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ rtl/tss_back.sv @@
// ----------------------------------------------------------------------------
// tss_back
// execution engine: entry memory, extremes tracking, binary search
// sequencer and the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tss_back #(
  parameter int DEPTH = tss_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  input  tss_pkg::cmd_t                      cmd,
  output logic                               cmd_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               lookup_found,
  output logic [tss_pkg::INDEX_W-1:0]        lookup_index,
  output logic [tss_pkg::COUNT_W-1:0]        entry_count,
  output logic                               extremes_valid,
  output logic signed [tss_pkg::PRICE_W-1:0] min_price,
  output logic [tss_pkg::TIME_W-1:0]         min_time,
  output logic signed [tss_pkg::PRICE_W-1:0] max_price,
  output logic [tss_pkg::TIME_W-1:0]         max_time,
  output logic                               order_warning,
  output logic                               store_full,
  output logic [tss_pkg::TIME_W-1:0]         item_time,
  output logic signed [tss_pkg::PRICE_W-1:0] item_price
);

  localparam int TW = tss_pkg::TIME_W;
  localparam int PW = tss_pkg::PRICE_W;
  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = CW + tss_pkg::INDEX_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PROBE = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_NBR   = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [TW+PW-1:0] mem [DEPTH];
  logic [TW+PW-1:0] rd_data;
  logic             we;
  logic             re;
  logic [IW-1:0]    raddr;

  logic [2:0]           state;
  tss_pkg::cmd_t        cur;
  logic [CW-1:0]        count;
  logic [TW-1:0]        last_time;
  logic                 have_ext;
  logic signed [PW-1:0] low_price;
  logic [TW-1:0]        low_time;
  logic signed [PW-1:0] high_price;
  logic [TW-1:0]        high_time;
  logic [CW-1:0]        lo;
  logic [CW-1:0]        hi1;
  logic [IW-1:0]        mid;
  logic                 found;
  logic                 warn;
  logic                 full;
  logic [TW-1:0]        itime;
  logic signed [PW-1:0] iprice;

  logic [CW:0]   mid_sum;
  logic [IW-1:0] mid_calc;
  logic [TW-1:0] rd_time;
  logic          read_ok;
  logic          at_first;
  logic          at_last;
  logic          cmp_found;
  logic          nbr_need;
  logic          go_lower;
  logic          nbr_found;
  logic          out_load;

  assign mid_sum  = (CW + 1)'(lo) + (CW + 1)'(hi1) - (CW + 1)'(1);
  assign mid_calc = mid_sum[IW:1];
  assign rd_time  = rd_data[TW+PW-1:PW];
  assign read_ok  = XW'(cmd.ridx) < XW'(count);
  assign at_first = (mid == '0);
  assign at_last  = (CW'(mid) + CW'(1)) == count;
  assign cmd_pop  = (state == S_IDLE) && cmd_valid;
  assign we       = cmd_pop && (cmd.op == tss_pkg::ACT_ADD) && (count != FULL_COUNT);
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    cmp_found = 1'b0;
    nbr_need  = 1'b0;
    go_lower  = rd_time > cur.tval;
    nbr_found = 1'b0;
    case (cur.mode)
      tss_pkg::MODE_EXACT: begin
        cmp_found = rd_time == cur.tval;
      end
      tss_pkg::MODE_NEXT: begin
        cmp_found = (rd_time >= cur.tval) && at_first;
        nbr_need  = (rd_time >= cur.tval) && !at_first;
        go_lower  = rd_time >= cur.tval;
        nbr_found = rd_time < cur.tval;
      end
      tss_pkg::MODE_PREV: begin
        cmp_found = (rd_time <= cur.tval) && at_last;
        nbr_need  = (rd_time <= cur.tval) && !at_last;
        nbr_found = rd_time > cur.tval;
      end
      default: begin
        cmp_found = 1'b0;
      end
    endcase
  end

  always_comb begin
    re    = 1'b0;
    raddr = mid_calc;
    case (state)
      S_IDLE: begin
        re    = cmd_pop && (cmd.op == tss_pkg::ACT_READ) && read_ok;
        raddr = IW'(cmd.ridx);
      end
      S_PROBE: begin
        re    = lo < hi1;
        raddr = mid_calc;
      end
      S_CMP: begin
        re    = !cmp_found && nbr_need;
        raddr = (cur.mode == tss_pkg::MODE_NEXT) ? mid - 1'b1 : mid + 1'b1;
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[count[IW-1:0]] <= {cmd.tval, cmd.price};
    end
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      have_ext   <= 1'b0;
      low_price  <= '0;
      low_time   <= '0;
      high_price <= '0;
      high_time  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            cur    <= cmd;
            found  <= 1'b0;
            warn   <= 1'b0;
            full   <= 1'b0;
            itime  <= '0;
            iprice <= '0;
            state  <= S_DONE;
            case (cmd.op)
              tss_pkg::ACT_ADD: begin
                if (count == FULL_COUNT) begin
                  full <= 1'b1;
                end else begin
                  if (!have_ext) begin
                    low_price  <= cmd.price;
                    low_time   <= cmd.tval;
                    high_price <= cmd.price;
                    high_time  <= cmd.tval;
                    have_ext   <= 1'b1;
                  end else begin
                    if ($signed(cmd.price) < $signed(low_price)) begin
                      low_price <= cmd.price;
                      low_time  <= cmd.tval;
                    end
                    if ($signed(high_price) < $signed(cmd.price)) begin
                      high_price <= cmd.price;
                      high_time  <= cmd.tval;
                    end
                  end
                  warn      <= (count != '0) && (cmd.tval < last_time);
                  last_time <= cmd.tval;
                  count     <= count + 1'b1;
                end
              end
              tss_pkg::ACT_CLEAR: begin
                count      <= '0;
                have_ext   <= 1'b0;
                low_price  <= '0;
                low_time   <= '0;
                high_price <= '0;
                high_time  <= '0;
              end
              tss_pkg::ACT_LOOKUP: begin
                lo  <= '0;
                hi1 <= count;
                if (cmd.mode_ok) begin
                  state <= S_PROBE;
                end
              end
              tss_pkg::ACT_READ: begin
                if (read_ok) begin
                  state <= S_READ;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_PROBE: begin
          if (lo < hi1) begin
            mid   <= mid_calc;
            state <= S_CMP;
          end else begin
            state <= S_DONE;
          end
        end
        S_CMP: begin
          if (cmp_found) begin
            found <= 1'b1;
            state <= S_DONE;
          end else if (nbr_need) begin
            state <= S_NBR;
          end else begin
            if (go_lower) begin
              hi1 <= CW'(mid);
            end else begin
              lo <= CW'(mid) + CW'(1);
            end
            state <= S_PROBE;
          end
        end
        S_NBR: begin
          if (nbr_found) begin
            found <= 1'b1;
            state <= S_DONE;
          end else begin
            if (cur.mode == tss_pkg::MODE_NEXT) begin
              hi1 <= CW'(mid);
            end else begin
              lo <= CW'(mid) + CW'(1);
            end
            state <= S_PROBE;
          end
        end
        S_READ: begin
          itime  <= rd_time;
          iprice <= rd_data[PW-1:0];
          state  <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      lookup_found   <= found;
      lookup_index   <= found ? tss_pkg::INDEX_W'(mid) : '0;
      entry_count    <= tss_pkg::COUNT_W'(count);
      extremes_valid <= have_ext;
      min_price      <= low_price;
      min_time       <= low_time;
      max_price      <= high_price;
      max_time       <= high_time;
      order_warning  <= warn;
      store_full     <= full;
      item_time      <= itime;
      item_price     <= iprice;
    end
  end

endmodule

@@ rtl/time_series_store_search.sv @@
// ----------------------------------------------------------------------------
// time_series_store_search
// append-only (time, price) table with min/max tracking and binary search
//
// input channel (in_valid / in_stall): one transfer per action: add, clear,
// lookup or read; fields not used by the action are ignored.
// output channel (out_valid / out_stall): exactly one result transfer per
// input transfer, in order.
// an input transfer passes an input register and a four-entry command queue,
// then the engine runs one command at a time.
// an add or clear passes the engine's idle and done states, a read also its
// read state; a lookup runs probe and compare states (one memory read) per
// probe, plus a neighbor-read state in next/previous mode, over at most
// ceil(log2(DEPTH+1)) probes. the engine holds one command in flight; the
// next starts the cycle after a result is loaded, so it takes no new command
// before the last is through. reset clears count and extremes at once; table
// contents are not cleared. a stalled result holds in the output register
// while the engine finishes at most one more command and the queue keeps
// taking work; the input stalls only once the queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module time_series_store_search #(
  parameter int DEPTH = tss_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         action,
  input  logic [tss_pkg::TIME_W-1:0]         entry_time,
  input  logic signed [tss_pkg::PRICE_W-1:0] entry_price,
  input  logic [tss_pkg::TIME_W-1:0]         query_time,
  input  logic [1:0]                         match_mode,
  input  logic [tss_pkg::INDEX_W-1:0]        read_index,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               lookup_found,
  output logic [tss_pkg::INDEX_W-1:0]        lookup_index,
  output logic [tss_pkg::COUNT_W-1:0]        entry_count,
  output logic                               extremes_valid,
  output logic signed [tss_pkg::PRICE_W-1:0] min_price,
  output logic [tss_pkg::TIME_W-1:0]         min_time,
  output logic signed [tss_pkg::PRICE_W-1:0] max_price,
  output logic [tss_pkg::TIME_W-1:0]         max_time,
  output logic                               order_warning,
  output logic                               store_full,
  output logic [tss_pkg::TIME_W-1:0]         item_time,
  output logic signed [tss_pkg::PRICE_W-1:0] item_price
);

  tss_pkg::cmd_t front_cmd;
  tss_pkg::cmd_t head_cmd;
  logic          front_valid;
  logic          queue_full;
  logic          queue_not_empty;
  logic          queue_pop;

  tss_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .entry_time  (entry_time),
    .entry_price (entry_price),
    .query_time  (query_time),
    .match_mode  (match_mode),
    .read_index  (read_index),
    .cmd_valid   (front_valid),
    .cmd         (front_cmd),
    .queue_full  (queue_full)
  );

  tss_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_cmd   (front_cmd),
    .full       (queue_full),
    .pop        (queue_pop),
    .not_empty  (queue_not_empty),
    .head       (head_cmd)
  );

  tss_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (queue_not_empty),
    .cmd            (head_cmd),
    .cmd_pop        (queue_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .lookup_found   (lookup_found),
    .lookup_index   (lookup_index),
    .entry_count    (entry_count),
    .extremes_valid (extremes_valid),
    .min_price      (min_price),
    .min_time       (min_time),
    .max_price      (max_price),
    .max_time       (max_time),
    .order_warning  (order_warning),
    .store_full     (store_full),
    .item_time      (item_time),
    .item_price     (item_price)
  );

endmodule

@@ rtl/tss_checker.sv @@
// ----------------------------------------------------------------------------
// tss_checker
// port-level checks on reset, result hold, extremes and the full-table case
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tss_checker #(
  parameter int DEPTH = tss_pkg::DEPTH_DEFAULT
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic                               lookup_found,
  input logic [tss_pkg::INDEX_W-1:0]        lookup_index,
  input logic [tss_pkg::COUNT_W-1:0]        entry_count,
  input logic                               extremes_valid,
  input logic signed [tss_pkg::PRICE_W-1:0] min_price,
  input logic [tss_pkg::TIME_W-1:0]         min_time,
  input logic signed [tss_pkg::PRICE_W-1:0] max_price,
  input logic [tss_pkg::TIME_W-1:0]         max_time,
  input logic                               order_warning,
  input logic                               store_full
);

  localparam logic [tss_pkg::COUNT_W-1:0] FULL_CNT = tss_pkg::COUNT_W'(DEPTH);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(lookup_index) && $stable(entry_count))
    else $error("stalled result changed");

  a_no_ext: assert property (@(posedge clk) disable iff (rst)
    out_valid && !extremes_valid |->
      min_price == '0 && max_price == '0 && min_time == '0 && max_time == '0)
    else $error("extremes not cleared");

  a_ext_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && extremes_valid |-> $signed(min_price) <= $signed(max_price))
    else $error("min price above max price");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && store_full |-> !order_warning && !lookup_found && entry_count == FULL_CNT)
    else $error("dropped add without full table");

endmodule

bind time_series_store_search tss_checker #(.DEPTH(DEPTH)) u_tss_checker (.*);

@@ tb/tb_time_series_store_search.sv @@
// ----------------------------------------------------------------------------
// tb_time_series_store_search
// self-checking bench for the time series table with min/max and search
//
// a directed table covers the field extremes, every action and match mode,
// ties, duplicates, out-of-order adds, misses and reads past the end; random
// sessions of clear, mostly ascending adds and a mix of lookups, reads, adds
// and clears follow, and a last session fills the table until adds drop.
// a table model predicts each result but those of pinned directed rows, all
// checked field by field against the oldest pending prediction. sender and
// receiver idle at random; the receiver stalls long once to back up the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_time_series_store_search;

  localparam int          DEPTH        = tss_pkg::DEPTH_DEFAULT;
  localparam logic [1:0]  MODE_BAD     = 2'd3;
  localparam logic [62:0] TMAX         = {63{1'b1}};
  localparam logic [31:0] PMAX         = 32'h7fff_ffff;
  localparam logic [31:0] PMIN         = 32'h8000_0000;
  localparam int          N_ROWS       = 25;
  localparam int          CHOKE_CYCLES = 400;
  localparam int          PHASE_ITEMS  = 40;
  localparam int          FILL_TAIL    = 20;
  localparam int          TAIL_CYCLES  = 60;
  localparam longint      LIMIT_NS     = 64'd10_000_000;

  typedef struct packed {
    logic [1:0]         action;
    logic [62:0]        etime;
    logic signed [31:0] eprice;
    logic [62:0]        qtime;
    logic [1:0]         mode;
    logic [9:0]         ridx;
  } request_t;

  typedef struct packed {
    logic               found;
    logic [9:0]         index;
    logic [10:0]        count;
    logic               ext_ok;
    logic signed [31:0] lo_price;
    logic [62:0]        lo_time;
    logic signed [31:0] hi_price;
    logic [62:0]        hi_time;
    logic               warn;
    logic               full;
    logic [62:0]        rd_time;
    logic signed [31:0] rd_price;
  } status_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [1:0] action;
  logic [tss_pkg::TIME_W-1:0] entry_time;
  logic signed [tss_pkg::PRICE_W-1:0] entry_price;
  logic [tss_pkg::TIME_W-1:0] query_time;
  logic [1:0] match_mode;
  logic [tss_pkg::INDEX_W-1:0] read_index;
  logic out_valid;
  logic out_stall;
  logic lookup_found;
  logic [tss_pkg::INDEX_W-1:0] lookup_index;
  logic [tss_pkg::COUNT_W-1:0] entry_count;
  logic extremes_valid;
  logic signed [tss_pkg::PRICE_W-1:0] min_price;
  logic [tss_pkg::TIME_W-1:0] min_time;
  logic signed [tss_pkg::PRICE_W-1:0] max_price;
  logic [tss_pkg::TIME_W-1:0] max_time;
  logic order_warning;
  logic store_full;
  logic [tss_pkg::TIME_W-1:0] item_time;
  logic signed [tss_pkg::PRICE_W-1:0] item_price;

  // table model
  logic [62:0]        time_tab [DEPTH];
  logic signed [31:0] price_tab [DEPTH];
  int                 tab_count = 0;
  logic               ext_ok = 1'b0;
  logic signed [31:0] lo_p = '0;
  logic [62:0]        lo_t = '0;
  logic signed [31:0] hi_p = '0;
  logic [62:0]        hi_t = '0;

  status_t  status_q [$];
  int       errors = 0;
  int       sent_count = 0;
  int       tx_idle_pct = 0;
  int       rx_idle_pct = 0;
  bit       choke_req = 1'b0;

  request_t rows [N_ROWS];
  bit       row_pinned [N_ROWS];
  status_t  row_status [N_ROWS];

  time_series_store_search #(.DEPTH(DEPTH)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [62:0] rand63();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[62:0];
  endfunction

  function automatic request_t req(logic [1:0] a, logic [62:0] et, logic [31:0] ep,
                                   logic [62:0] qt, logic [1:0] m, logic [9:0] ri);
    request_t r;
    r.action = a;
    r.etime  = et;
    r.eprice = ep;
    r.qtime  = qt;
    r.mode   = m;
    r.ridx   = ri;
    return r;
  endfunction

  function automatic bit bisect_times(logic [62:0] t, logic [1:0] m, output int where);
    int lo, hi, mid, last;
    logic [62:0] v;
    lo = 0;
    hi = tab_count - 1;
    last = tab_count - 1;
    where = 0;
    if (m == MODE_BAD) return 1'b0;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      v = time_tab[mid];
      case (m)
        tss_pkg::MODE_EXACT: begin
          if (v == t) begin
            where = mid;
            return 1'b1;
          end
          if (v > t) hi = mid - 1; else lo = mid + 1;
        end
        tss_pkg::MODE_NEXT: begin
          if (v >= t && (mid == 0 || time_tab[mid - 1] < t)) begin
            where = mid;
            return 1'b1;
          end
          if (v < t) lo = mid + 1; else hi = mid - 1;
        end
        default: begin
          if (v <= t && (mid == last || time_tab[mid + 1] > t)) begin
            where = mid;
            return 1'b1;
          end
          if (v > t) hi = mid - 1; else lo = mid + 1;
        end
      endcase
    end
    return 1'b0;
  endfunction

  // applies one request to the table model and returns the status it reports
  function automatic status_t table_after(request_t r);
    status_t s;
    int where;
    s = '0;
    case (r.action)
      tss_pkg::ACT_ADD: begin
        if (tab_count >= DEPTH) begin
          s.full = 1'b1;
        end else begin
          if (!ext_ok) begin
            lo_p = r.eprice;
            lo_t = r.etime;
            hi_p = r.eprice;
            hi_t = r.etime;
            ext_ok = 1'b1;
          end else begin
            if ($signed(r.eprice) < $signed(lo_p)) begin
              lo_p = r.eprice;
              lo_t = r.etime;
            end
            if ($signed(hi_p) < $signed(r.eprice)) begin
              hi_p = r.eprice;
              hi_t = r.etime;
            end
          end
          if (tab_count != 0 && r.etime < time_tab[tab_count - 1]) s.warn = 1'b1;
          time_tab[tab_count] = r.etime;
          price_tab[tab_count] = r.eprice;
          tab_count++;
        end
      end
      tss_pkg::ACT_CLEAR: begin
        tab_count = 0;
        ext_ok = 1'b0;
        lo_p = '0;
        lo_t = '0;
        hi_p = '0;
        hi_t = '0;
      end
      tss_pkg::ACT_LOOKUP: begin
        if (bisect_times(r.qtime, r.mode, where)) begin
          s.found = 1'b1;
          s.index = where[9:0];
        end
      end
      default: begin
        if (r.ridx < tab_count) begin
          s.rd_time  = time_tab[r.ridx];
          s.rd_price = price_tab[r.ridx];
        end
      end
    endcase
    s.count    = tab_count[10:0];
    s.ext_ok   = ext_ok;
    s.lo_price = lo_p;
    s.lo_time  = lo_t;
    s.hi_price = hi_p;
    s.hi_time  = hi_t;
    return s;
  endfunction

  // random request shaped by the current table contents
  function automatic request_t draw(logic [1:0] act, bit noisy);
    request_t r;
    logic [62:0] last, step, base;
    logic [63:0] sum;
    r.action = act;
    r.etime  = rand63();
    r.eprice = $urandom;
    r.qtime  = rand63();
    r.mode   = 2'($urandom_range(0, 3));
    r.ridx   = 10'($urandom_range(0, 1023));
    if (noisy) begin
      r.action = 2'($urandom_range(0, 3));
      return r;
    end
    case (act)
      tss_pkg::ACT_ADD: begin
        if (tab_count == 0) begin
          case ($urandom_range(0, 3))
            0: r.etime = '0;
            1: r.etime = rand63();
            2: r.etime = rand63() >> 20;
            default: r.etime = TMAX - 63'($urandom_range(0, 2000));
          endcase
        end else begin
          last = time_tab[tab_count - 1];
          case ($urandom_range(0, 7))
            0: step = '0;
            1, 2: step = 63'($urandom_range(1, 3));
            3, 4: step = 63'($urandom_range(1, 1 << 20));
            5: step = rand63() >> $urandom_range(20, 40);
            default: step = 63'($urandom);
          endcase
          if ($urandom_range(0, 19) == 0) begin
            r.etime = (step > last) ? '0 : last - step;
          end else begin
            sum = {1'b0, last} + {1'b0, step};
            r.etime = sum[63] ? TMAX : sum[62:0];
          end
        end
        case ($urandom_range(0, 9))
          0: r.eprice = PMIN;
          1: r.eprice = PMAX;
          2: if (tab_count != 0) r.eprice = price_tab[$urandom_range(0, tab_count - 1)];
          3: r.eprice = $signed($urandom_range(0, 200)) - 100;
          default: r.eprice = $urandom;
        endcase
      end
      tss_pkg::ACT_LOOKUP: begin
        if (tab_count != 0 && $urandom_range(0, 9) < 6) begin
          base = time_tab[$urandom_range(0, tab_count - 1)];
          case ($urandom_range(0, 3))
            0: r.qtime = (base != '0) ? base - 63'd1 : base;
            1: r.qtime = (base != TMAX) ? base + 63'd1 : base;
            default: r.qtime = base;
          endcase
        end else begin
          case ($urandom_range(0, 3))
            0: r.qtime = '0;
            1: r.qtime = TMAX;
            default: r.qtime = rand63();
          endcase
        end
        r.mode = ($urandom_range(0, 15) == 0) ? MODE_BAD : 2'($urandom_range(0, 2));
      end
      tss_pkg::ACT_READ: begin
        if (tab_count != 0 && $urandom_range(0, 9) < 8) begin
          r.ridx = 10'($urandom_range(0, tab_count - 1));
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send(request_t r, bit pinned, status_t pin);
    status_t s;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= r.action;
    entry_time  <= r.etime;
    entry_price <= r.eprice;
    query_time  <= r.qtime;
    match_mode  <= r.mode;
    read_index  <= r.ridx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    s = table_after(r);
    status_q.push_back(pinned ? pin : s);
    sent_count++;
  endtask

  task automatic run_session(int adds, int tail);
    int p;
    logic [1:0] act;
    send(draw(tss_pkg::ACT_CLEAR, 1'b0), 1'b0, '0);
    repeat (adds) send(draw(tss_pkg::ACT_ADD, 1'b0), 1'b0, '0);
    repeat (tail) begin
      p = $urandom_range(0, 99);
      act = (p < 45) ? tss_pkg::ACT_LOOKUP : (p < 75) ? tss_pkg::ACT_READ :
            (p < 95) ? tss_pkg::ACT_ADD : tss_pkg::ACT_CLEAR;
      send(draw(act, 1'b0), 1'b0, '0);
    end
  endtask

  task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) note_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin : result_check
    status_t want;
    if (!rst && out_valid && !out_stall) begin
      if (status_q.size() == 0) begin
        note_mismatch("result transfer with nothing pending", '0, '0);
      end else begin
        want = status_q.pop_front();
        check_field("lookup_found", 64'(lookup_found), 64'(want.found));
        check_field("lookup_index", 64'(lookup_index), 64'(want.index));
        check_field("entry_count", 64'(entry_count), 64'(want.count));
        check_field("extremes_valid", 64'(extremes_valid), 64'(want.ext_ok));
        check_field("min_price", 64'(min_price), 64'(want.lo_price));
        check_field("min_time", 64'(min_time), 64'(want.lo_time));
        check_field("max_price", 64'(max_price), 64'(want.hi_price));
        check_field("max_time", 64'(max_time), 64'(want.hi_time));
        check_field("order_warning", 64'(order_warning), 64'(want.warn));
        check_field("store_full", 64'(store_full), 64'(want.full));
        check_field("item_time", 64'(item_time), 64'(want.rd_time));
        check_field("item_price", 64'(item_price), 64'(want.rd_price));
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (choke_req) begin
        choke_req = 1'b0;
        out_stall <= 1'b1;
        repeat (CHOKE_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("time_series_store_search regression: fail");
    $finish;
  end

  initial begin : stimulus
    status_t one_entry, two_entries;
    int target;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    action      <= tss_pkg::ACT_ADD;
    entry_time  <= '0;
    entry_price <= '0;
    query_time  <= '0;
    match_mode  <= tss_pkg::MODE_EXACT;
    read_index  <= '0;

    foreach (row_status[i]) row_status[i] = '0;
    one_entry = '0;
    one_entry.count    = 11'd1;
    one_entry.ext_ok   = 1'b1;
    one_entry.lo_price = PMAX;
    one_entry.lo_time  = TMAX;
    one_entry.hi_price = PMAX;
    one_entry.hi_time  = TMAX;
    two_entries = one_entry;
    two_entries.count    = 11'd2;
    two_entries.lo_price = PMIN;
    two_entries.lo_time  = '0;
    two_entries.warn     = 1'b1;

    rows[0]  = req(tss_pkg::ACT_READ,   '0, '0, '0, tss_pkg::MODE_EXACT, '0);
    rows[1]  = req(tss_pkg::ACT_LOOKUP, '0, '0, '0, tss_pkg::MODE_EXACT, '0);
    rows[2]  = req(tss_pkg::ACT_LOOKUP, '0, '0, TMAX, MODE_BAD, '0);
    rows[3]  = req(tss_pkg::ACT_ADD,    TMAX, PMAX, '0, tss_pkg::MODE_EXACT, '0);
    rows[4]  = req(tss_pkg::ACT_ADD,    '0, PMIN, '0, tss_pkg::MODE_EXACT, '0);
    rows[5]  = req(tss_pkg::ACT_READ,   '0, '0, '0, tss_pkg::MODE_EXACT, 10'd1);
    rows[6]  = req(tss_pkg::ACT_LOOKUP, '0, '0, TMAX, tss_pkg::MODE_PREV, '0);
    rows[7]  = req(tss_pkg::ACT_CLEAR,  '0, '0, '0, tss_pkg::MODE_EXACT, '0);
    rows[8]  = req(tss_pkg::ACT_READ,   '0, '0, '0, tss_pkg::MODE_EXACT, 10'd1023);
    rows[9]  = req(tss_pkg::ACT_ADD,    63'd100, 32'sd5, '0, tss_pkg::MODE_EXACT, '0);
    rows[10] = req(tss_pkg::ACT_ADD,    63'd200, 32'sd5, '0, tss_pkg::MODE_EXACT, '0);
    rows[11] = req(tss_pkg::ACT_ADD,    63'd300, -32'sd3, '0, tss_pkg::MODE_EXACT, '0);
    rows[12] = req(tss_pkg::ACT_ADD,    63'd300, 32'sd9, '0, tss_pkg::MODE_EXACT, '0);
    rows[13] = req(tss_pkg::ACT_ADD,    63'd500, 32'sd0, '0, tss_pkg::MODE_EXACT, '0);
    rows[14] = req(tss_pkg::ACT_LOOKUP, '0, '0, 63'd300,  tss_pkg::MODE_EXACT, '0);
    rows[15] = req(tss_pkg::ACT_LOOKUP, '0, '0, 63'd250,  tss_pkg::MODE_EXACT, '0);
    rows[16] = req(tss_pkg::ACT_LOOKUP, '0, '0, 63'd250,  tss_pkg::MODE_NEXT,  '0);
    rows[17] = req(tss_pkg::ACT_LOOKUP, '0, '0, 63'd600,  tss_pkg::MODE_NEXT,  '0);
    rows[18] = req(tss_pkg::ACT_LOOKUP, '0, '0, 63'd50,   tss_pkg::MODE_PREV,  '0);
    rows[19] = req(tss_pkg::ACT_LOOKUP, '0, '0, 63'd1000, tss_pkg::MODE_PREV,  '0);
    rows[20] = req(tss_pkg::ACT_LOOKUP, '0, '0, 63'd300,  MODE_BAD, '0);
    rows[21] = req(tss_pkg::ACT_READ,   '0, '0, '0, tss_pkg::MODE_EXACT, 10'd4);
    rows[22] = req(tss_pkg::ACT_READ,   '0, '0, '0, tss_pkg::MODE_EXACT, 10'd5);
    rows[23] = req(tss_pkg::ACT_ADD,    63'd50, 32'sd1, '0, tss_pkg::MODE_EXACT, '0);
    rows[24] = req(tss_pkg::ACT_LOOKUP, '0, '0, 63'd100,  tss_pkg::MODE_NEXT,  '0);
    row_pinned[0] = 1'b1;
    row_pinned[1] = 1'b1;
    row_pinned[2] = 1'b1;
    row_pinned[3] = 1'b1;
    row_status[3] = one_entry;
    row_pinned[4] = 1'b1;
    row_status[4] = two_entries;
    row_pinned[7] = 1'b1;
    row_pinned[8] = 1'b1;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 6;
    rx_idle_pct = 66;
    for (int i = 0; i < N_ROWS; i++) send(rows[i], row_pinned[i], row_status[i]);

    target = sent_count;
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 66 : 0;
      rx_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 6 : 0;
      if (phase == 2) begin
        // fill the table past its end under a long hold-off, then probe the top entry
        choke_req = 1'b1;
        run_session(DEPTH + 6, FILL_TAIL);
        send(req(tss_pkg::ACT_READ, rand63(), $urandom, rand63(), tss_pkg::MODE_EXACT,
                 10'd1023), 1'b0, '0);
        send(req(tss_pkg::ACT_LOOKUP, rand63(), $urandom, TMAX, tss_pkg::MODE_PREV, '0),
             1'b0, '0);
      end else begin
        target += PHASE_ITEMS;
        while (sent_count < target) begin
          if ($urandom_range(0, 9) == 0) send(draw(tss_pkg::ACT_ADD, 1'b1), 1'b0, '0);
          else run_session($urandom_range(1, 40), $urandom_range(5, 30));
        end
      end
    end
    in_valid <= 1'b0;

    while (status_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("time_series_store_search regression: pass");
    end else begin
      $display("time_series_store_search regression: fail");
    end
    $finish;
  end

endmodule
